/* hw/rtl/muad_pkg.sv */
// Shared types and constants for the message unit array deframer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package muad_pkg;

  // Default width of the length accumulator and content counter
  localparam int LENGTH_BITS = 32;
  // Length text ends after this many characters
  localparam int LENGTH_CAP = 55;
  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam int FIELD_LEN_W = 6;
  localparam int UNIT_CNT_W  = 17;

  typedef enum logic [3:0] {
    PH_QOS     = 4'b0001,
    PH_KEY     = 4'b0010,
    PH_LEN     = 4'b0100,
    PH_CONTENT = 4'b1000
  } phase_e;

  typedef enum logic [3:0] {
    LS_EMPTY  = 4'b0001,
    LS_DIGITS = 4'b0010,
    LS_TRAIL  = 4'b0100,
    LS_BAD    = 4'b1000
  } len_stat_e;

  typedef enum logic [2:0] {
    KIND_QOS_BYTE     = 3'd0,
    KIND_QOS_END      = 3'd1,
    KIND_KEY_BYTE     = 3'd2,
    KIND_KEY_END      = 3'd3,
    KIND_LEN_CHAR     = 3'd4,
    KIND_LEN_END      = 3'd5,
    KIND_CONTENT_BYTE = 3'd6
  } kind_e;

  // Classified input byte, as queued between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_nul;
    logic       is_blank;
    logic       is_digit;
    logic [3:0] digit;
  } item_t;

  // One result item
  typedef struct packed {
    kind_e        kind;
    logic [7:0]   out_byte;
    logic [15:0]  unit_index;
    logic [31:0]  length_value;
    logic         length_bad;
    logic         done_res;
    logic         truncated;
    logic [15:0]  unit_count;
  } result_t;

endpackage

/* hw/rtl/message_unit_array_deframer.sv */
// Top level of the message unit array deframer.
// Depends on muad_pkg, muad_front, muad_fifo and muad_back.
`timescale 1ns / 1ps

// Message unit array deframer
//
// Input channel (in_valid_i / in_ready_o): one byte of the serialized unit
// array per transfer, last_i set on the final byte of a blob. Output channel
// (out_valid_o / out_ready_i): exactly one tagged result per input byte, in
// order: kind, the byte itself, unit index, parsed length on length end,
// and on the last byte the unit count and a truncation flag.
//
// Throughput: one byte per cycle while out_ready_i does not stall the output.
// Every byte updates the parser state; the length digits go through one
// shift-add multiply-by-ten and an overflow check on the accumulator width.
// Path: each byte passes through the queue, then the output register of the
// back end, before its result is valid.
//
// Stalls: the front takes bytes into a small queue while a result waits in
// the output register, so up to QUEUE_DEPTH + 1 bytes are in flight; in_ready_o
// drops only once the queue is full.
// Reset: queue and output empty, parser in the qos phase with no unit open.
// After the last byte the parser returns to that same state by itself.

module message_unit_array_deframer #(
  parameter int LengthBits = muad_pkg::LENGTH_BITS,
  parameter int QueueDepth = muad_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] unit_index_o,
  output logic [31:0] length_value_o,
  output logic        length_bad_o,
  output logic        done_res_o,
  output logic        truncated_o,
  output logic [15:0] unit_count_o
);

  muad_pkg::item_t   front_item;
  muad_pkg::item_t   head_item;
  logic              head_valid;
  logic              head_pop;
  muad_pkg::result_t result;

  // classify each byte on the way in
  muad_front u_front (
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .item_o      (front_item)
  );

  // decouples input transfers from output stalls
  muad_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .ready_o     (in_ready_o),
    .pop_i       (head_pop),
    .valid_o     (head_valid),
    .head_o      (head_item)
  );

  // field parser and result register
  muad_back #(
    .LengthBits (LengthBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (head_valid),
    .item_i      (head_item),
    .pop_o       (head_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign kind_o         = result.kind;
  assign out_byte_o     = result.out_byte;
  assign unit_index_o   = result.unit_index;
  assign length_value_o = result.length_value;
  assign length_bad_o   = result.length_bad;
  assign done_res_o     = result.done_res;
  assign truncated_o    = result.truncated;
  assign unit_count_o   = result.unit_count;

  // a bad length always reads as zero
  a_bad_len_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_bad_o |-> (length_value_o == 32'd0))
    else $error("bad length with nonzero value");

  // length fields only on length end
  a_len_only_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != muad_pkg::KIND_LEN_END)
    |-> !length_bad_o && (length_value_o == 32'd0))
    else $error("length fields set outside length end");

  // end-of-blob fields only with done
  a_done_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> !truncated_o && (unit_count_o == 16'd0))
    else $error("blob summary set before last byte");

  // terminators carry no byte
  a_term_no_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((kind_o == muad_pkg::KIND_QOS_END) || (kind_o == muad_pkg::KIND_KEY_END)
    || (kind_o == muad_pkg::KIND_LEN_END)) |-> (out_byte_o == 8'd0))
    else $error("terminator result carries a byte");

endmodule

/* hw/rtl/muad_front.sv */
// Front of the deframer: takes raw bytes and classifies them.
// Depends on muad_pkg.
`timescale 1ns / 1ps

module muad_front (
  input  logic [7:0]     data_byte_i,
  input  logic           last_i,
  output muad_pkg::item_t item_o
);

  logic blank;
  logic digit;

  assign blank = (data_byte_i == 8'd32) || ((data_byte_i >= 8'd9) && (data_byte_i <= 8'd13));
  assign digit = (data_byte_i >= 8'd48) && (data_byte_i <= 8'd57);

  always_comb begin
    item_o.data     = data_byte_i;
    item_o.last     = last_i;
    item_o.is_nul   = (data_byte_i == 8'd0);
    item_o.is_blank = blank;
    item_o.is_digit = digit;
    item_o.digit    = data_byte_i[3:0];  // '0'..'9' are 0x30..0x39
  end

endmodule

/* hw/rtl/muad_fifo.sv */
// Small queue of classified items between front and back.
// Depends on muad_pkg.
`timescale 1ns / 1ps

module muad_fifo #(
  parameter int Depth = muad_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  muad_pkg::item_t push_item_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output muad_pkg::item_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  muad_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign ready_o = (count_q != CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* hw/rtl/muad_back.sv */
// Back of the deframer: field parser, length accumulator and output register.
// Depends on muad_pkg.
`timescale 1ns / 1ps

module muad_back #(
  parameter int LengthBits = muad_pkg::LENGTH_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  muad_pkg::item_t   item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output muad_pkg::result_t result_o
);

  localparam int ProdW = LengthBits + 4;
  localparam int MaxW  = (LengthBits > 32) ? LengthBits : 32;
  localparam int FW    = muad_pkg::FIELD_LEN_W;
  localparam int UW    = muad_pkg::UNIT_CNT_W;

  muad_pkg::phase_e    phase_q, phase_d;
  muad_pkg::len_stat_e lstat_q, lstat_d;
  logic [LengthBits-1:0] accum_q, accum_d;
  logic [LengthBits-1:0] left_q, left_d;
  logic [UW-1:0]         ucnt_q, ucnt_d;
  logic                  uopen_q, uopen_d;
  logic [FW-1:0]         flen_q, flen_d;
  logic                  out_valid_q;
  muad_pkg::result_t     res_q, res_d;

  logic [ProdW-1:0]      prod;
  logic [LengthBits-1:0] lv_full;
  logic [LengthBits-1:0] left_m;
  logic [MaxW-1:0]       lv_wide;

  assign pop_o       = valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  // accum * 10 + digit, with headroom to spot overflow
  assign prod = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1) + ProdW'(item_i.digit);

  always_comb begin
    phase_d = phase_q;
    lstat_d = lstat_q;
    accum_d = accum_q;
    left_d  = left_q;
    ucnt_d  = ucnt_q;
    uopen_d = uopen_q;
    flen_d  = flen_q;
    lv_full = '0;
    left_m  = left_q;
    res_d   = '0;
    res_d.kind = muad_pkg::KIND_QOS_BYTE;

    case (phase_q)
      muad_pkg::PH_QOS: begin
        uopen_d = 1'b1;
        if (!uopen_q && (ucnt_q != UW'(65536))) begin
          ucnt_d = ucnt_q + 1'b1;
        end
        if (item_i.is_nul) begin
          res_d.kind = muad_pkg::KIND_QOS_END;
          phase_d    = muad_pkg::PH_KEY;
          flen_d     = '0;
        end else begin
          res_d.kind     = muad_pkg::KIND_QOS_BYTE;
          res_d.out_byte = item_i.data;
        end
      end
      muad_pkg::PH_KEY: begin
        if (item_i.is_nul) begin
          res_d.kind = muad_pkg::KIND_KEY_END;
          phase_d    = muad_pkg::PH_LEN;
          flen_d     = '0;
          lstat_d    = muad_pkg::LS_EMPTY;
          accum_d    = '0;
        end else begin
          res_d.kind     = muad_pkg::KIND_KEY_BYTE;
          res_d.out_byte = item_i.data;
          if (flen_q != '1) begin
            flen_d = flen_q + 1'b1;
          end
        end
      end
      muad_pkg::PH_LEN: begin
        if (item_i.is_nul || (flen_q >= FW'(muad_pkg::LENGTH_CAP))) begin
          res_d.kind       = muad_pkg::KIND_LEN_END;
          res_d.length_bad = (lstat_q == muad_pkg::LS_EMPTY) || (lstat_q == muad_pkg::LS_BAD);
          lv_full          = res_d.length_bad ? '0 : accum_q;
          flen_d           = '0;
          if (lv_full == '0) begin
            phase_d = muad_pkg::PH_QOS;
            uopen_d = 1'b0;
          end else begin
            left_d  = lv_full;
            phase_d = muad_pkg::PH_CONTENT;
          end
        end else begin
          res_d.kind     = muad_pkg::KIND_LEN_CHAR;
          res_d.out_byte = item_i.data;
          flen_d         = flen_q + 1'b1;
          if (lstat_q != muad_pkg::LS_BAD) begin
            if (item_i.is_blank) begin
              if (lstat_q == muad_pkg::LS_DIGITS) begin
                lstat_d = muad_pkg::LS_TRAIL;
              end
            end else if (item_i.is_digit) begin
              if (lstat_q == muad_pkg::LS_TRAIL) begin
                lstat_d = muad_pkg::LS_BAD;
              end else if (lstat_q == muad_pkg::LS_EMPTY) begin
                accum_d = LengthBits'(item_i.digit);
                lstat_d = muad_pkg::LS_DIGITS;
              end else if (|prod[ProdW-1:LengthBits]) begin
                lstat_d = muad_pkg::LS_BAD;
              end else begin
                accum_d = prod[LengthBits-1:0];
              end
            end else begin
              lstat_d = muad_pkg::LS_BAD;
            end
          end
        end
      end
      muad_pkg::PH_CONTENT: begin
        res_d.kind     = muad_pkg::KIND_CONTENT_BYTE;
        res_d.out_byte = item_i.data;
        if (left_q != '0) begin
          left_m = left_q - 1'b1;
        end
        left_d = left_m;
        if (left_m == '0) begin
          phase_d = muad_pkg::PH_QOS;
          uopen_d = 1'b0;
        end
      end
      default: begin
        phase_d = muad_pkg::PH_QOS;
      end
    endcase

    lv_wide            = MaxW'(lv_full);
    res_d.length_value = lv_wide[31:0];
    res_d.unit_index   = (ucnt_d == '0) ? 16'd0 : 16'(ucnt_d - 1'b1);
    res_d.done_res     = item_i.last;

    if (item_i.last) begin
      case (phase_d)
        muad_pkg::PH_QOS:     res_d.truncated = uopen_d;
        muad_pkg::PH_CONTENT: res_d.truncated = 1'b1;
        default:              res_d.truncated = (flen_d != '0);
      endcase
      res_d.unit_count = (ucnt_d == UW'(65536)) ? 16'hFFFF : ucnt_d[15:0];
      // end of blob: back to the reset state
      phase_d = muad_pkg::PH_QOS;
      lstat_d = muad_pkg::LS_EMPTY;
      accum_d = '0;
      left_d  = '0;
      ucnt_d  = '0;
      uopen_d = 1'b0;
      flen_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= muad_pkg::PH_QOS;
      lstat_q     <= muad_pkg::LS_EMPTY;
      accum_q     <= '0;
      left_q      <= '0;
      ucnt_q      <= '0;
      uopen_q     <= 1'b0;
      flen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        lstat_q <= lstat_d;
        accum_q <= accum_d;
        left_q  <= left_d;
        ucnt_q  <= ucnt_d;
        uopen_q <= uopen_d;
        flen_q  <= flen_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule
